// File: sv/smp_pkg.sv
// Shared types and constants of the styled markup parser.
`timescale 1ns / 1ps

package smp_pkg;

  localparam int WindowBytesDef = 4;
  localparam int QueueDepthDef  = 4;
  localparam int TagSpan        = 4;
  localparam int OutDataBits    = 40;

  localparam logic [15:0] CpNewline = 16'h000A;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_LT,
    CLS_GT,
    CLS_CR,
    CLS_LF,
    CLS_BAR
  } chr_cls_e;

  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_B,
    TAG_I,
    TAG_U,
    TAG_DIGIT,
    TAG_SLASH
  } tag_cls_e;

  typedef struct packed {
    logic [15:0] cp;
    chr_cls_e    cls;
    tag_cls_e    tag;
  } win_ent_t;

  typedef struct packed {
    win_ent_t ent;
    logic     fin;
  } q_ent_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] cp;
    logic        bold;
    logic        italic;
    logic        underline;
    logic [3:0]  color;
    logic [15:0] unk;
    logic        last;
  } res_t;

endpackage

// File: sv/smp_front.sv
// Front end: takes input beats, classifies each byte and maps it to a code point.
`timescale 1ns / 1ps

module smp_front (
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [7:0]      s_byte_i,
  input  logic            s_last_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output smp_pkg::q_ent_t q_ent_o
);

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBar   = 8'h7C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpB   = 8'h42;
  localparam logic [7:0] ChUpI   = 8'h49;
  localparam logic [7:0] ChUpU   = 8'h55;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  localparam logic [15:0] Cp1252High [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  logic [7:0] up_byte;

  always_comb begin
    up_byte = s_byte_i;
    if (s_byte_i inside {[ChLoA:ChLoZ]}) begin
      up_byte = s_byte_i - CaseGap;
    end

    if (s_byte_i inside {[8'h80:8'h9F]}) begin
      q_ent_o.ent.cp = Cp1252High[s_byte_i[4:0]];
    end else begin
      q_ent_o.ent.cp = {8'h00, s_byte_i};
    end

    case (s_byte_i)
      ChLt:    q_ent_o.ent.cls = smp_pkg::CLS_LT;
      ChGt:    q_ent_o.ent.cls = smp_pkg::CLS_GT;
      ChCr:    q_ent_o.ent.cls = smp_pkg::CLS_CR;
      ChLf:    q_ent_o.ent.cls = smp_pkg::CLS_LF;
      ChBar:   q_ent_o.ent.cls = smp_pkg::CLS_BAR;
      default: q_ent_o.ent.cls = smp_pkg::CLS_OTHER;
    endcase

    if (up_byte inside {[ChZero:ChNine]}) begin
      q_ent_o.ent.tag = smp_pkg::TAG_DIGIT;
    end else begin
      case (up_byte)
        ChUpB:   q_ent_o.ent.tag = smp_pkg::TAG_B;
        ChUpI:   q_ent_o.ent.tag = smp_pkg::TAG_I;
        ChUpU:   q_ent_o.ent.tag = smp_pkg::TAG_U;
        ChSlash: q_ent_o.ent.tag = smp_pkg::TAG_SLASH;
        default: q_ent_o.ent.tag = smp_pkg::TAG_NONE;
      endcase
    end

    q_ent_o.fin = s_last_i;
  end

  assign s_tready_o = q_ready_i;
  assign q_push_o   = s_tvalid_i & q_ready_i;

endmodule

// File: sv/smp_queue.sv
// Short queue of classified bytes between the front end and the back end.
`timescale 1ns / 1ps

module smp_queue #(
  parameter int Depth = smp_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  smp_pkg::q_ent_t ent_i,
  output logic            ready_o,
  output logic            valid_o,
  output smp_pkg::q_ent_t ent_o,
  input  logic            pop_i
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  smp_pkg::q_ent_t mem_q [Depth];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign ent_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/smp_back.sv
// Back end: lookahead window, tag decode, style state and the output register.
`timescale 1ns / 1ps

module smp_back #(
  parameter int WindowBytes = smp_pkg::WindowBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  smp_pkg::q_ent_t q_ent_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output smp_pkg::res_t   out_o
);

  localparam int FW = $clog2(WindowBytes + 1);

  typedef smp_pkg::win_ent_t win_arr_t [WindowBytes];

  typedef enum logic [1:0] {
    ACT_CHAR,
    ACT_NL,
    ACT_TAG,
    ACT_END
  } act_e;

  typedef struct packed {
    logic              run;
    act_e              act;
    logic [FW-1:0]     drop;
    logic              cnt_tot;
    logic              cnt_pend;
    smp_pkg::tag_cls_e tag;
    logic              tag_close;
  } dec_t;

  // Decides the next action on a window of n entries.
  function automatic dec_t scan(win_arr_t w, logic [FW-1:0] n, logic fin);
    dec_t          d;
    logic          gt_found;
    logic [FW-1:0] e;
    d        = '0;
    d.act    = ACT_CHAR;
    d.drop   = FW'(1);
    d.tag    = smp_pkg::TAG_NONE;
    gt_found = 1'b0;
    e        = '0;
    for (int k = 1; k < WindowBytes; k++) begin
      if (!gt_found && FW'(k) < n && w[k].cls == smp_pkg::CLS_GT) begin
        gt_found = 1'b1;
        e        = FW'(k);
      end
    end
    if (n == '0) begin
      d.run = fin;
      d.act = ACT_END;
    end else begin
      case (w[0].cls)
        smp_pkg::CLS_LT: begin
          d.run = gt_found || (n >= FW'(smp_pkg::TagSpan)) || fin;
          if (gt_found && e == FW'(2) &&
              (w[1].tag inside {smp_pkg::TAG_B, smp_pkg::TAG_I, smp_pkg::TAG_U,
                                smp_pkg::TAG_DIGIT})) begin
            d.act  = ACT_TAG;
            d.drop = FW'(3);
            d.tag  = w[1].tag;
          end else if (gt_found && e == FW'(3) && w[1].tag == smp_pkg::TAG_SLASH &&
                       (w[2].tag inside {smp_pkg::TAG_B, smp_pkg::TAG_I,
                                         smp_pkg::TAG_U})) begin
            d.act       = ACT_TAG;
            d.drop      = FW'(4);
            d.tag       = w[2].tag;
            d.tag_close = 1'b1;
          end else begin
            d.cnt_tot  = gt_found;
            d.cnt_pend = !gt_found && (n >= FW'(smp_pkg::TagSpan));
          end
        end
        smp_pkg::CLS_CR: begin
          d.run = (n >= FW'(2)) || fin;
          d.act = ACT_NL;
          if (n >= FW'(2) && w[1].cls == smp_pkg::CLS_LF) begin
            d.drop = FW'(2);
          end
        end
        smp_pkg::CLS_LF, smp_pkg::CLS_BAR: begin
          d.run = 1'b1;
          d.act = ACT_NL;
        end
        default: begin
          d.run = 1'b1;
        end
      endcase
    end
    return d;
  endfunction

  function automatic win_arr_t shift_win(win_arr_t w, logic [FW-1:0] k);
    win_arr_t r;
    r = w;
    for (int j = 0; j < WindowBytes; j++) begin
      for (int s = 1; s <= smp_pkg::TagSpan && j + s < WindowBytes; s++) begin
        if (k == FW'(s)) begin
          r[j] = w[j + s];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  win_arr_t      win_q, win_d, eff, rem;
  logic [FW-1:0] fill_q, fill_d, eff_n, rem_n;
  logic          fin_q, fin_d, eff_fin;
  logic          bold_q, bold_d, ital_q, ital_d, undl_q, undl_d;
  logic [3:0]    color_q, color_d;
  logic [15:0]   pend_q, pend_d, tot_q, tot_d, pend_base, tot_base;
  logic          out_valid_q;
  smp_pkg::res_t out_q, res;
  dec_t          dec_w, dec_e, dec_r;
  logic          take, emits, out_free, go, adv, no_more;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    dec_w = scan(win_q, fill_q, fin_q);
    take  = !dec_w.run && q_valid_i;

    for (int j = 0; j < WindowBytes; j++) begin
      eff[j] = (take && FW'(j) == fill_q) ? q_ent_i.ent : win_q[j];
    end
    eff_n   = take ? fill_q + 1'b1 : fill_q;
    eff_fin = take ? q_ent_i.fin : fin_q;

    dec_e = scan(eff, eff_n, eff_fin);
    rem   = shift_win(eff, dec_e.drop);
    rem_n = eff_n - dec_e.drop;
    dec_r = scan(rem, rem_n, 1'b0);

    // no further result in this run once the rest stalls or is one whole tag
    no_more = !dec_r.run || (dec_r.act == ACT_TAG && dec_r.drop == rem_n);

    emits   = (dec_e.act != ACT_TAG);
    go      = dec_e.run && (!emits || out_free);
    adv     = take ? (!dec_e.run || go) : go;
    q_pop_o = take && adv;

    if (take && q_ent_i.ent.cls == smp_pkg::CLS_GT) begin
      tot_base  = sat_add(tot_q, pend_q);
      pend_base = '0;
    end else begin
      tot_base  = tot_q;
      pend_base = pend_q;
    end

    res           = '0;
    res.kind      = (dec_e.act == ACT_END);
    res.last      = (dec_e.act == ACT_END) || (!eff_fin && no_more);
    case (dec_e.act)
      ACT_CHAR: begin
        res.cp        = eff[0].cp;
        res.bold      = bold_q;
        res.italic    = ital_q;
        res.underline = undl_q;
        res.color     = color_q;
      end
      ACT_NL: begin
        res.cp = smp_pkg::CpNewline;
      end
      ACT_END: begin
        res.unk = tot_q;
      end
      default: begin
        res.cp = '0;
      end
    endcase

    win_d   = win_q;
    fill_d  = fill_q;
    fin_d   = fin_q;
    bold_d  = bold_q;
    ital_d  = ital_q;
    undl_d  = undl_q;
    color_d = color_q;
    pend_d  = pend_q;
    tot_d   = tot_q;

    if (adv) begin
      win_d  = eff;
      fill_d = eff_n;
      fin_d  = eff_fin;
      pend_d = pend_base;
      tot_d  = tot_base;
    end

    if (go) begin
      win_d  = rem;
      fill_d = rem_n;
      tot_d  = dec_e.cnt_tot ? sat_add(tot_base, 16'd1) : tot_base;
      pend_d = dec_e.cnt_pend ? sat_add(pend_base, 16'd1) : pend_base;
      case (dec_e.act)
        ACT_NL: begin
          bold_d  = 1'b0;
          ital_d  = 1'b0;
          undl_d  = 1'b0;
          color_d = '0;
        end
        ACT_TAG: begin
          case (dec_e.tag)
            smp_pkg::TAG_DIGIT: color_d = eff[1].cp[3:0];
            smp_pkg::TAG_B:     bold_d  = !dec_e.tag_close;
            smp_pkg::TAG_I:     ital_d  = !dec_e.tag_close;
            smp_pkg::TAG_U:     undl_d  = !dec_e.tag_close;
            default:            color_d = color_q;
          endcase
        end
        ACT_END: begin
          fill_d  = '0;
          fin_d   = 1'b0;
          bold_d  = 1'b0;
          ital_d  = 1'b0;
          undl_d  = 1'b0;
          color_d = '0;
          pend_d  = '0;
          tot_d   = '0;
        end
        default: begin
          fin_d = eff_fin;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (go && emits) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      fin_q       <= 1'b0;
      bold_q      <= 1'b0;
      ital_q      <= 1'b0;
      undl_q      <= 1'b0;
      color_q     <= '0;
      pend_q      <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      fin_q   <= fin_d;
      bold_q  <= bold_d;
      ital_q  <= ital_d;
      undl_q  <= undl_d;
      color_q <= color_d;
      pend_q  <= pend_d;
      tot_q   <= tot_d;
      if (go && emits) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: sv/styled_markup_parser.sv
// Top level of the styled markup parser: front end, byte queue, back end.
//
//  channel  dir  tdata                                   tuser      tlast
//  s_axis   in   [7:0] byte                              -          end of text
//  m_axis   out  [15:0] code point, [16] bold,           item kind  last of run
//                [17] italic, [18] underline,
//                [22:19] color, [38:23] unknown tags
//
// The back end takes one action per cycle: one result, one consumed tag, or
// taking in a byte that only waits in the window; a result waits while the
// output stalls. Each result and each tag that a byte completes is an action
// of its own, and a final byte also gives the end item. A byte passes through
// the queue and the output register before its result is accepted. No clearing
// pass after reset. The queue lets the input keep flowing while the output
// stalls; while a beat waits, the back end still takes in bytes and tags.
`timescale 1ns / 1ps

module styled_markup_parser #(
  parameter int WindowBytes = smp_pkg::WindowBytesDef,
  parameter int QueueDepth  = smp_pkg::QueueDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,   // in_byte
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // code_point, is_bold, is_italic, is_underline, color_index, unknown_tags, pad
  output logic [smp_pkg::OutDataBits-1:0] m_axis_tdata_o,
  output logic                            m_axis_tuser_o,   // item_kind
  output logic                            m_axis_tlast_o
);

  smp_pkg::q_ent_t push_ent, pop_ent;
  smp_pkg::res_t   res;
  logic            q_ready, q_push, q_valid, q_pop;

  smp_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_byte_i   (s_axis_tdata_i),
    .s_last_i   (s_axis_tlast_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_ent_o    (push_ent)
  );

  smp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ent_i   (push_ent),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .ent_o   (pop_ent),
    .pop_i   (q_pop)
  );

  smp_back #(
    .WindowBytes (WindowBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ent_i     (pop_ent),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {1'b0, res.unk, res.color, res.underline, res.italic, res.bold,
                           res.cp};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule
